[rtl/bfdh_pkg.sv]
// Shared constants and types for the double-hash Bloom filter.
`default_nettype none
package bfdh_pkg;

  localparam int MAX_WORDS  = 1024;
  localparam int MAX_HASHES = 16;
  localparam int WORD_W     = 64;
  localparam int ADDR_W     = $clog2(MAX_WORDS);
  localparam int NW_W       = 11;
  localparam int NH_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_BITS   = 58;
  localparam int DIV_CNT_W  = 6;

  localparam logic [NW_W-1:0] NW_RESET = 11'd1024;
  localparam logic [NH_W-1:0] NH_RESET = 5'd7;
  localparam logic [NW_W-1:0] NW_MAX   = 11'(MAX_WORDS);
  localparam logic [NH_W-1:0] NH_MAX   = 5'(MAX_HASHES);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_WORDS  = 1'b0,
    REG_NUM_HASHES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

[rtl/bfdh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfdh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/bloom_filter_double_hash.sv]
// Bloom filter with double-hash probing over a 1024 x 64-bit word store.
// For each probe of an add or query item, the probe position is
// reduced modulo the configured word count by a one-bit-per-cycle restoring
// divider (58 steps), then the word store is read once and, for an add, written back.
// An add runs all k probes; a query stops at the first clear bit. The default
// k is 7, the maximum 16. A clear, and the clearing pass after reset, sweep
// all 1024 words one per cycle while in_stall is high. Results wait in an
// output register, so the next item is taken while a found bit is pending.
`default_nettype none
module bloom_filter_double_hash
  import bfdh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_command,
  input  wire logic [63:0]           in_hash_low,
  input  wire logic [63:0]           in_hash_high,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_found,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [NW_W-1:0]      num_words_r;
  logic [NH_W-1:0]      num_hashes_r;
  logic [NW_W-1:0]      w_r, w_nxt;
  logic [NH_W-1:0]      k_r, k_nxt;
  logic [NH_W-1:0]      i_r, i_nxt;
  logic                 is_add_r, is_add_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [63:0]          stride_r, stride_nxt;
  logic [DIV_BITS-1:0]  div_sh_r, div_sh_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW_W-1:0]      rem_r, rem_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic                 hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;

  logic                 in_xfer;
  logic                 out_free;
  logic [NW_W:0]        div_t;
  logic [WORD_W-1:0]    mask;
  logic                 bit_set;
  logic                 last_probe;
  logic [NW_W-1:0]      eff_w;
  logic [NH_W-1:0]      eff_k;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  bfdh_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign div_t      = {rem_r, div_sh_r[DIV_BITS-1]};
  assign mask       = WORD_W'(1) << acc_r[5:0];
  assign bit_set    = (ram_rdata & mask) != '0;
  assign last_probe = (i_r == k_r - NH_W'(1));

  always_comb begin
    if (num_words_r == '0) begin
      eff_w = NW_W'(1);
    end else if (num_words_r > NW_MAX) begin
      eff_w = NW_MAX;
    end else begin
      eff_w = num_words_r;
    end
    if (num_hashes_r == '0) begin
      eff_k = NH_W'(1);
    end else if (num_hashes_r > NH_MAX) begin
      eff_k = NH_MAX;
    end else begin
      eff_k = num_hashes_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == ADDR_W'(MAX_WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_t'(in_command))
            CMD_CLEAR:           state_nxt = ST_CLEAR;
            CMD_ADD, CMD_QUERY:  state_nxt = ST_DIV;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!is_add_r && !bit_set) begin
          state_nxt = ST_RESULT;
        end else if (last_probe) begin
          state_nxt = is_add_r ? ST_IDLE : ST_RESULT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = rem_r[ADDR_W-1:0];
    ram_wdata     = ram_rdata | mask;
    ram_raddr     = rem_r[ADDR_W-1:0];
    w_nxt         = w_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    is_add_nxt    = is_add_r;
    acc_nxt       = acc_r;
    stride_nxt    = stride_r;
    div_sh_nxt    = div_sh_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    clr_nxt       = clr_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        clr_nxt    = '0;
        w_nxt      = eff_w;
        k_nxt      = eff_k;
        i_nxt      = '0;
        is_add_nxt = (in_command == CMD_ADD);
        acc_nxt    = in_hash_low;
        stride_nxt = in_hash_high;
        div_sh_nxt = in_hash_low[63:6];
        cnt_nxt    = DIV_CNT_W'(DIV_BITS - 1);
        rem_nxt    = '0;
        hit_nxt    = 1'b1;
      end
      ST_DIV: begin
        // restoring step: remainder stays below the word count
        if (div_t >= {1'b0, w_r}) begin
          rem_nxt = NW_W'(div_t - {1'b0, w_r});
        end else begin
          rem_nxt = div_t[NW_W-1:0];
        end
        div_sh_nxt = {div_sh_r[DIV_BITS-2:0], 1'b0};
        cnt_nxt    = cnt_r - DIV_CNT_W'(1);
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (is_add_r) begin
          ram_we = 1'b1;
        end else if (!bit_set) begin
          hit_nxt = 1'b0;
        end
        acc_nxt    = acc_r + stride_r;
        div_sh_nxt = acc_nxt[63:6];
        cnt_nxt    = DIV_CNT_W'(DIV_BITS - 1);
        rem_nxt    = '0;
        i_nxt      = i_r + NH_W'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      num_words_r  <= NW_RESET;
      num_hashes_r <= NH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_NUM_WORDS:  num_words_r  <= cfg_wdata[NW_W-1:0];
          REG_NUM_HASHES: num_hashes_r <= cfg_wdata[NH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    is_add_r    <= is_add_nxt;
    acc_r       <= acc_nxt;
    stride_r    <= stride_nxt;
    div_sh_r    <= div_sh_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> state_r == ST_IDLE)
    else $error("input transfer outside idle");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_READ) |-> rem_r < w_r)
    else $error("probe remainder out of range");

  a_no_write_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !ram_we)
    else $error("store written during division");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_free) |=> out_valid_r)
    else $error("query result not presented");

endmodule
`default_nettype wire
